### rtl/bis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared widths, register indexes and item types for the scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int MaxSrcWidth  = 256;
    localparam int MaxSrcHeight = 256;
    localparam int MaxDstDim    = 4096;
    localparam int FracBits     = 8;

    localparam int XW       = $clog2(MaxSrcWidth);
    localparam int YW       = $clog2(MaxSrcHeight);
    localparam int AddrW    = XW + YW;
    localparam int Depth    = MaxSrcWidth * MaxSrcHeight;
    localparam int PixW     = 24;
    localparam int CoordW   = 12;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 13;
    // Quotient width of the position divider: integer part plus fraction.
    localparam int QW       = XW + 1 + FracBits;
    // Dividend width: coord * (size-1) shifted by FracBits.
    localparam int NW       = CoordW + XW + 1 + FracBits;
    localparam int DW       = 13;

    localparam logic [CfgIdxW-1:0] RegSrcW = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSrcH = 2'd1;
    localparam logic [CfgIdxW-1:0] RegDstW = 2'd2;
    localparam logic [CfgIdxW-1:0] RegDstH = 2'd3;

    localparam logic OpLoad   = 1'b0;
    localparam logic OpSample = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CoordW-1:0] coord_x;
        logic [CoordW-1:0] coord_y;
        logic [PixW-1:0]   pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PixW-1:0] pixel_out;
        logic            coord_error;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } t_cfg_item;

endpackage
`default_nettype wire

### rtl/bis_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scaler channel interface
// Valid/ready channel carrying one payload of configurable type.
// ----------------------------------------------------------------------------
interface bis_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/bis_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/bis_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined position divider
// Restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bis_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [bis_pkg::NW-1:0]    i_num,
    input  wire logic [bis_pkg::DW-1:0]    i_den,
    output logic      [bis_pkg::QW-1:0]    o_quo
);
    localparam int NW = bis_pkg::NW;
    localparam int DW = bis_pkg::DW;
    localparam int QW = bis_pkg::QW;

    // Quotient never exceeds (size-1) << FracBits, so only QW bits are formed.
    // The high dividend bits above QW start as partial remainder.
    logic [NW-1:0]   r_rem [QW+1];
    logic [NW-1:0]   r_num [QW+1];
    logic [DW-1:0]   r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];

    assign r_rem[0] = i_num >> QW;
    assign r_num[0] = i_num;
    assign r_den[0] = i_den;
    assign r_q[0]   = '0;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [NW-1:0] n_trial;
        logic [NW-1:0] r_rem_q;
        logic [NW-1:0] r_num_q;
        logic [DW-1:0] r_den_q;
        logic [QW-1:0] r_q_q;

        // Shift in the next dividend bit and try a subtract.
        assign n_trial = {r_rem[s][NW-2:0], r_num[s][QW-1-s]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_trial >= NW'(r_den[s])) begin
                    r_rem_q <= n_trial - NW'(r_den[s]);
                    r_q_q   <= {r_q[s][QW-2:0], 1'b1};
                end else begin
                    r_rem_q <= n_trial;
                    r_q_q   <= {r_q[s][QW-2:0], 1'b0};
                end
                r_num_q <= r_num[s];
                r_den_q <= r_den[s];
            end
        end

        assign r_rem[s+1] = r_rem_q;
        assign r_num[s+1] = r_num_q;
        assign r_den[s+1] = r_den_q;
        assign r_q[s+1]   = r_q_q;
    end

    assign o_quo = r_q[QW];
endmodule
`default_nettype wire

### rtl/bilinear_image_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image scaler, RGB888
// Holds a source frame and answers destination samples by bilinear blending.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg: write channel, index 0..3 selects source width, source height,
//          destination width, destination height. Write only while idle.
//   i_in:  items with op, coord_x, coord_y, pixel_in. A load (op 0) stores
//          one source pixel and gives no result. A sample (op 1) gives one
//          item on o_out: the blended pixel and an error flag for a sample
//          outside the destination size.
//   Throughput is one item per cycle unless the receiver stalls. The source
//   frame is stored in four banks split by column and row parity, so the four
//   neighbors of a sample are read together. A sample passes from acceptance
//   to a valid result through the dividend register, 17 stages of the pipelined
//   position divider, the memory read, the weight register, the product
//   register and the output register.
//   The whole pipeline advances only when the output register is free or
//   being taken, so a stall of the receiver freezes it and drops nothing.
//   Reset clears all control state; the frame itself is not cleared.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bis_if.sink      i_cfg,
    bis_if.sink      i_in,
    bis_if.source    o_out
);
    localparam int XW     = bis_pkg::XW;
    localparam int YW     = bis_pkg::YW;
    localparam int FB     = bis_pkg::FracBits;
    localparam int QW     = bis_pkg::QW;
    localparam int NW     = bis_pkg::NW;
    localparam int DW     = bis_pkg::DW;
    localparam int PW     = bis_pkg::PixW;
    localparam int CW     = bis_pkg::CoordW;
    localparam int BAW    = XW + YW - 2;
    localparam int BDEPTH = bis_pkg::Depth / 4;
    localparam int S      = 1 << FB;

    typedef struct packed {
        logic          vld;
        logic          op;
        logic          err;
        logic [XW-1:0] lx;
        logic [YW-1:0] ly;
        logic          lok;
        logic [PW-1:0] pix;
    } t_tag;

    // Configuration registers and clamped sizes.
    logic [8:0]  r_sw, r_sh;
    logic [12:0] r_dw, r_dh;
    logic [XW:0] n_sw, n_sh;
    logic [DW-1:0] n_dw, n_dh;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 9'd1; r_sh <= 9'd1; r_dw <= 13'd1; r_dh <= 13'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                bis_pkg::RegSrcW: r_sw <= i_cfg.data.data[8:0];
                bis_pkg::RegSrcH: r_sh <= i_cfg.data.data[8:0];
                bis_pkg::RegDstW: r_dw <= i_cfg.data.data;
                bis_pkg::RegDstH: r_dh <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_sw = (r_sw == 0) ? (XW+1)'(1) :
               (r_sw > bis_pkg::MaxSrcWidth) ? (XW+1)'(bis_pkg::MaxSrcWidth) : r_sw[XW:0];
        n_sh = (r_sh == 0) ? (XW+1)'(1) :
               (r_sh > bis_pkg::MaxSrcHeight) ? (XW+1)'(bis_pkg::MaxSrcHeight) : r_sh[XW:0];
        n_dw = (r_dw == 0) ? DW'(1) :
               (r_dw > bis_pkg::MaxDstDim) ? DW'(bis_pkg::MaxDstDim) : r_dw;
        n_dh = (r_dh == 0) ? DW'(1) :
               (r_dh > bis_pkg::MaxDstDim) ? DW'(bis_pkg::MaxDstDim) : r_dh;
    end

    // Pipeline advance: output register empty or being drained.
    logic r_ov;
    logic adv;
    assign adv = !r_ov || o_out.ready;
    assign i_in.ready = adv;

    // Stage 0: products for the dividends, registered before the dividers.
    logic           acc;
    logic [NW-1:0]  r_nx, r_ny;
    logic [DW-1:0]  r_ddx, r_ddy;
    t_tag           r_t0;
    t_tag           n_t0;
    assign acc = i_in.valid && adv;

    always_comb begin
        n_t0.vld = acc;
        n_t0.op  = i_in.data.op;
        n_t0.err = (13'(i_in.data.coord_x) >= n_dw) || (13'(i_in.data.coord_y) >= n_dh);
        n_t0.lx  = i_in.data.coord_x[XW-1:0];
        n_t0.ly  = i_in.data.coord_y[YW-1:0];
        n_t0.lok = (i_in.data.coord_x < CW'(bis_pkg::MaxSrcWidth)) &&
                   (i_in.data.coord_y < CW'(bis_pkg::MaxSrcHeight));
        n_t0.pix = i_in.data.pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0.vld <= 1'b0;
        end else if (adv) begin
            r_t0 <= n_t0;
        end
        if (adv) begin
            r_nx  <= NW'((NW'(i_in.data.coord_x) * NW'(n_sw - 1'b1)) << FB);
            r_ny  <= NW'((NW'(i_in.data.coord_y) * NW'(n_sh - 1'b1)) << FB);
            r_ddx <= (n_dw <= 1) ? DW'(0) : n_dw - 1'b1;
            r_ddy <= (n_dh <= 1) ? DW'(0) : n_dh - 1'b1;
        end
    end

    // Dividers; a zero divisor only occurs for size 1, where the quotient is
    // replaced by zero through the size-one flags.
    logic [QW-1:0] w_qx, w_qy;
    bis_div u_divx (
        .i_clk(i_clk), .i_en(adv), .i_num(r_nx), .i_den(r_ddx), .o_quo(w_qx)
    );
    bis_div u_divy (
        .i_clk(i_clk), .i_en(adv), .i_num(r_ny), .i_den(r_ddy), .o_quo(w_qy)
    );

    // Item tags and size-one flags travel beside the divider pipeline.
    t_tag          r_tp [QW];
    logic [QW-1:0] r_z1x, r_z1y;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tp[0] <= r_t0;
            for (int k = 1; k < QW; k++) r_tp[k] <= r_tp[k-1];
            r_z1x <= {r_z1x[QW-2:0], r_ddx == 0};
            r_z1y <= {r_z1y[QW-2:0], r_ddy == 0};
        end
    end

    // Valid bit of divider output is reset-controlled separately.
    logic [QW-1:0] r_dv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (adv) begin
            r_dv <= {r_dv[QW-2:0], r_t0.vld};
        end
    end

    // Stage M: split positions, clamp neighbors, form bank addresses.
    t_tag          w_td;
    logic [QW-1:0] w_pu, w_pv;
    logic [XW:0]   w_x0, w_x1;
    logic [YW:0]   w_y0, w_y1;
    always_comb begin
        w_td     = r_tp[QW-1];
        w_td.vld = r_dv[QW-1];
        w_pu     = r_z1x[QW-1] ? QW'(0) : w_qx;
        w_pv     = r_z1y[QW-1] ? QW'(0) : w_qy;
        w_x0     = (XW+1)'(w_pu >> FB);
        w_y0     = (YW+1)'(w_pv >> FB);
        w_x1     = (w_x0 + 1'b1 < n_sw) ? w_x0 + 1'b1 : w_x0;
        w_y1     = (w_y0 + 1'b1 < n_sh) ? w_y0 + 1'b1 : w_y0;
    end

    // Bank b = {row parity, column parity}; each bank gets one read address.
    logic [BAW-1:0] n_ra [4];
    logic [XW-1:0]  w_xe, w_xo;
    logic [YW-1:0]  w_ye, w_yo;
    logic           w_xsw, w_ysw;
    always_comb begin
        // Of x0/x1 one is even and one odd unless clamped (then equal).
        w_xsw = w_x0[0];
        w_ysw = w_y0[0];
        w_xe  = w_xsw ? w_x1[XW-1:0] : w_x0[XW-1:0];
        w_xo  = w_xsw ? w_x0[XW-1:0] : w_x1[XW-1:0];
        w_ye  = w_ysw ? w_y1[YW-1:0] : w_y0[YW-1:0];
        w_yo  = w_ysw ? w_y0[YW-1:0] : w_y1[YW-1:0];
        n_ra[0] = {w_ye[YW-1:1], w_xe[XW-1:1]};
        n_ra[1] = {w_ye[YW-1:1], w_xo[XW-1:1]};
        n_ra[2] = {w_yo[YW-1:1], w_xe[XW-1:1]};
        n_ra[3] = {w_yo[YW-1:1], w_xo[XW-1:1]};
    end

    // Loads write in this same stage so writes stay ordered with reads.
    logic [PW-1:0] w_rd [4];
    logic          w_we;
    assign w_we = w_td.vld && (w_td.op == bis_pkg::OpLoad) && w_td.lok;
    for (genvar b = 0; b < 4; b++) begin : g_bank
        bis_ram #(.WIDTH(PW), .DEPTH(BDEPTH)) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we && (w_td.ly[0] == b[1]) && (w_td.lx[0] == b[0])),
            .i_waddr({w_td.ly[YW-1:1], w_td.lx[XW-1:1]}),
            .i_wdata(w_td.pix),
            .i_re   (adv),
            .i_raddr(n_ra[b]),
            .o_rdata(w_rd[b])
        );
    end

    // Read stage registers.
    logic          r_rv, r_rerr;
    logic          r_xsw, r_ysw, r_xeq, r_yeq;
    logic [FB-1:0] r_fx, r_fy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (adv) begin
            r_rv <= w_td.vld && (w_td.op == bis_pkg::OpSample);
        end
        if (adv) begin
            r_rerr <= w_td.err;
            r_xsw  <= w_xsw;
            r_ysw  <= w_ysw;
            r_xeq  <= (w_x0 == w_x1);
            r_yeq  <= (w_y0 == w_y1);
            r_fx   <= w_pu[FB-1:0];
            r_fy   <= w_pv[FB-1:0];
        end
    end

    // Route banks to corners, compute weights.
    logic [PW-1:0]     w_c [4];
    logic [2*FB+1:0]   w_w [4];
    logic [1:0]        w_b00, w_b10, w_b01, w_b11;
    always_comb begin
        w_b00 = {r_ysw, r_xsw};
        w_b10 = {r_ysw, r_xeq ? r_xsw : !r_xsw};
        w_b01 = {r_yeq ? r_ysw : !r_ysw, r_xsw};
        w_b11 = {r_yeq ? r_ysw : !r_ysw, r_xeq ? r_xsw : !r_xsw};
        w_c[0] = w_rd[w_b00];
        w_c[1] = w_rd[w_b10];
        w_c[2] = w_rd[w_b01];
        w_c[3] = w_rd[w_b11];
        w_w[0] = (2*FB+2)'((S - r_fx) * (S - r_fy));
        w_w[1] = (2*FB+2)'(r_fx * (S - r_fy));
        w_w[2] = (2*FB+2)'((S - r_fx) * r_fy);
        w_w[3] = (2*FB+2)'(r_fx * r_fy);
    end

    // Registers after weight multiply.
    logic          r_m1v, r_m1err;
    logic [PW-1:0]   r_m1c [4];
    logic [2*FB+1:0] r_m1w [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0;
        end else if (adv) begin
            r_m1v <= r_rv;
        end
        if (adv) begin
            r_m1err <= r_rerr;
            r_m1c   <= w_c;
            r_m1w   <= w_w;
        end
    end

    // Channel products, one per corner and channel.
    localparam int PRW = 2*FB + 10;
    logic          r_m2v, r_m2err;
    logic [PRW-1:0] r_pr [3][4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2v <= 1'b0;
        end else if (adv) begin
            r_m2v <= r_m1v;
        end
        if (adv) begin
            r_m2err <= r_m1err;
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 4; k++) begin
                    r_pr[ch][k] <= PRW'(r_m1c[k][ch*8 +: 8]) * PRW'(r_m1w[k]);
                end
            end
        end
    end

    // Sum, round half up, saturate; then output register.
    logic [PW-1:0]  n_pix;
    logic [PRW+1:0] w_sum [3];
    logic [PRW+1:0] w_sh  [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_sum[ch] = (PRW+2)'(r_pr[ch][0]) + (PRW+2)'(r_pr[ch][1])
                      + (PRW+2)'(r_pr[ch][2]) + (PRW+2)'(r_pr[ch][3])
                      + (PRW+2)'(S * S / 2);
            w_sh[ch]  = w_sum[ch] >> (2*FB);
            n_pix[ch*8 +: 8] = (w_sh[ch] > 255) ? 8'hFF : w_sh[ch][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_m2v;
        end
        if (adv) begin
            o_out.data.coord_error <= r_m2err;
            o_out.data.pixel_out   <= r_m2err ? '0 : n_pix;
        end
    end
    assign o_out.valid = r_ov;
endmodule
`default_nettype wire

### rtl/bis_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scaler port checker
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bis_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic o_out_valid,
    input wire logic o_out_ready,
    input wire logic i_cfg_ready,
    input wire logic o_err,
    input wire logic [23:0] o_pix
);
    // A stalled item holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid && $stable(o_pix))
        else $error("result changed while stalled");
    // Input side is open whenever the output is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");
    // Error results carry a zero pixel.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_err |-> o_pix == 24'd0)
        else $error("error result with nonzero pixel");
    // Configuration is always taken.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");
endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .o_out_valid(o_out.valid), .o_out_ready(o_out.ready),
    .i_cfg_ready(i_cfg.ready), .o_err(o_out.data.coord_error),
    .o_pix(o_out.data.pixel_out)
);
`default_nettype wire
